FILE: rtl/lsbr_pkg.sv
package lsbr_pkg;

	// field widths
	localparam int LBA_W   = 20;
	localparam int LEN_W   = 12;
	localparam int SECT_W  = 48;
	localparam int BIU_W   = 13;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// block geometry
	localparam int SPB       = 8;
	localparam int SPB_SHIFT = 3;
	localparam int MAX_REQ   = 2048;
	localparam int NBLK_W    = $clog2(MAX_REQ / SPB + 1);
	// block index reach: first block of the request plus the request span
	localparam int BIDX_W    = LBA_W - SPB_SHIFT + 1;

	localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(4096);

	// map entry: valid bit over the physical sector
	localparam int ENTRY_W = SECT_W + 1;

	// command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;

	// result status codes
	localparam logic [1:0] ST_WRITE = 2'd0;
	localparam logic [1:0] ST_REMAP = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;
	localparam logic [1:0] ST_PASS  = 2'd3;

	// register word index
	localparam logic REG_BLOCKS_IN_USE = 1'b0;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WMAP,
		S_RLOOK,
		S_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic clear_step;
		logic map_step;
		logic look_done;
		logic emit;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_write;
		logic in_lookup;
		logic map_more;
		logic clear_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/lsbr_ram.sv
module lsbr_ram #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/lsbr_ctrl.sv
module lsbr_ctrl import lsbr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (stat.in_write) state_d = S_WMAP;
					else if (stat.in_lookup) state_d = S_RLOOK;
					else state_d = S_EMIT;
				end
			end
			S_WMAP: begin
				if (!stat.map_more) state_d = S_EMIT;
			end
			S_RLOOK: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd.clear_step = 1'b1;
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_WMAP:  cmd.map_step  = stat.map_more;
			S_RLOOK: cmd.look_done = 1'b1;
			S_EMIT:  cmd.emit      = stat.out_free;
			default: cmd = '0;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && stat.clear_last) |=> state_q == S_IDLE)
		else $error("clearing pass did not hand over to idle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ready)
		else $error("new word taken before the previous one finished");
`endif

endmodule

FILE: rtl/lsbr_dp.sv
module lsbr_dp import lsbr_pkg::*; #(
	parameter int MAX_BLOCKS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_cmd_t           cmd,
	output dp_stat_t           stat,
	// input word
	input  logic [1:0]         in_cmd,
	input  logic [LBA_W-1:0]   lba,
	input  logic [LEN_W-1:0]   req_len,
	// output word
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [SECT_W-1:0]  phys_sector,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(MAX_BLOCKS);

	logic [BIU_W-1:0]     blocks_in_use_q;
	logic [SECT_W-1:0]    wp_q;
	logic [BIDX_W-1:0]    idx_q;
	logic [NBLK_W-1:0]    cnt_q;
	logic [SECT_W-1:0]    map_val_q;
	logic [SPB_SHIFT-1:0] off_q;
	logic [AW-1:0]        clr_idx_q;
	logic [1:0]           res_status_q;
	logic [SECT_W-1:0]    res_phys_q;
	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [SECT_W-1:0]    out_phys_q;

	logic [BIDX_W-1:0]    first;
	logic [LEN_W-1:0]     len_sat;
	logic [LEN_W:0]       len_round;
	logic [NBLK_W-1:0]    nblk;
	logic                 first_in_range;
	logic                 idx_in_range;
	logic                 is_write;
	logic                 is_read;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ENTRY_W-1:0]   ram_wdata;
	logic [ENTRY_W-1:0]   ram_rdata;
	logic                 reg_wr;

	// register port, no wait states
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BLOCKS_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_in_use_q <= BIU_RESET;
		end else if (reg_wr) begin
			blocks_in_use_q <= pwdata[BIU_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BLOCKS_IN_USE) prdata = PDATA_W'(blocks_in_use_q);
	end

	// request decode
	assign is_write  = (in_cmd == CMD_WRITE);
	assign is_read   = (in_cmd == CMD_READ);
	assign first     = {1'b0, lba[LBA_W-1:SPB_SHIFT]};
	assign len_sat   = (req_len > LEN_W'(MAX_REQ)) ? LEN_W'(MAX_REQ) : req_len;
	assign len_round = {1'b0, len_sat} + (LEN_W+1)'(SPB - 1);
	assign nblk      = NBLK_W'(len_round >> SPB_SHIFT);

	// block limit is the smaller of the register and the table depth
	assign first_in_range = (first < BIDX_W'(blocks_in_use_q))
		&& (32'(first) < 32'(MAX_BLOCKS));
	assign idx_in_range = (idx_q < BIDX_W'(blocks_in_use_q))
		&& (32'(idx_q) < 32'(MAX_BLOCKS));

	assign stat.in_write   = is_write && (req_len != '0);
	assign stat.in_lookup  = is_read && first_in_range;
	assign stat.map_more   = (cnt_q != '0) && idx_in_range;
	assign stat.clear_last = (clr_idx_q == AW'(MAX_BLOCKS - 1));
	assign stat.out_free   = !out_valid_q || out_ready;

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clear_step) begin
			clr_idx_q <= clr_idx_q + AW'(1);
		end
	end

	// write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (cmd.accept && stat.in_write) begin
			wp_q <= wp_q + SECT_W'(len_sat);
		end
	end

	// request capture, map walk and result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q     <= first;
			cnt_q     <= nblk;
			map_val_q <= wp_q;
			off_q     <= lba[SPB_SHIFT-1:0];
			if (is_write) begin
				res_status_q <= ST_WRITE;
				res_phys_q   <= stat.in_write ? wp_q : '0;
			end else if (is_read) begin
				res_status_q <= ST_ZERO;
				res_phys_q   <= '0;
			end else begin
				res_status_q <= ST_PASS;
				res_phys_q   <= SECT_W'(lba);
			end
		end
		if (cmd.map_step) begin
			idx_q     <= idx_q + BIDX_W'(1);
			cnt_q     <= cnt_q - NBLK_W'(1);
			map_val_q <= map_val_q + SECT_W'(SPB);
		end
		if (cmd.look_done) begin
			if (ram_rdata[SECT_W]) begin
				res_status_q <= ST_REMAP;
				res_phys_q   <= ram_rdata[SECT_W-1:0] + SECT_W'(off_q);
			end else begin
				res_status_q <= ST_ZERO;
				res_phys_q   <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_phys_q   <= res_phys_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign phys_sector = out_phys_q;

	// map table: clear sweep or map step writes, lookup reads at accept
	assign ram_we    = cmd.clear_step || cmd.map_step;
	assign ram_waddr = cmd.clear_step ? clr_idx_q : idx_q[AW-1:0];
	assign ram_wdata = cmd.clear_step ? '0 : {1'b1, map_val_q};

	lsbr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_BLOCKS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.accept && stat.in_lookup),
		.raddr(first[AW-1:0]),
		.rdata(ram_rdata)
	);

`ifndef NO_ASSERTIONS
	a_map_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.map_step |-> idx_in_range && !cmd.clear_step)
		else $error("map write outside the block limit");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending word");
	a_wp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.accept |=> $stable(wp_q))
		else $error("write pointer moved without a request");
`endif

endmodule

FILE: rtl/log_structured_block_remapper.sv
// channel   | handshake                      | payload
// ----------+--------------------------------+---------------------------------
// input     | in_valid / in_ready            | cmd, lba, req_len
// output    | out_valid / out_ready          | status, phys_sector
// register  | psel, penable, pwrite / pready | paddr, pwdata, prdata
//
// A nonempty write stores one map entry per block, ceil(len/8) blocks with len
// capped at 2048 (fewer when the block limit is hit), one map entry per cycle
// through the single write port of the map memory. A read of a block inside the
// limit passes a lookup state (registered memory read); other words go straight
// from idle to emit. After reset a clearing pass empties the map; no word is
// taken meanwhile, register writes are. A full output register holds the
// finished result while the next word is taken; only the emit step waits.
module log_structured_block_remapper import lsbr_pkg::*; #(
	parameter int MAX_BLOCKS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [LBA_W-1:0]   lba,
	input  logic [LEN_W-1:0]   req_len,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [SECT_W-1:0]  phys_sector,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	ctl_cmd_t ctl;
	dp_stat_t dstat;

	lsbr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (dstat),
		.cmd     (ctl)
	);

	lsbr_dp #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl),
		.stat       (dstat),
		.in_cmd     (cmd),
		.lba        (lba),
		.req_len    (req_len),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.phys_sector(phys_sector),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

endmodule
